@@ design/ifcf_pkg.sv @@
package ifcf_pkg;

   // Frame geometry, counted in bytes from the Ethernet destination address.
   localparam logic [15:0] MAX_FRAME_BYTES = 16'hFFFF;
   localparam logic [15:0] ETH_HDR_BYTES   = 16'd14;
   localparam logic [15:0] IP6_END_BYTES   = 16'd54;
   localparam logic [15:0] TYPE_HI_POS     = 16'd12;
   localparam logic [15:0] TYPE_LO_POS     = 16'd13;
   localparam logic [15:0] PLEN_HI_POS     = 16'd18;
   localparam logic [15:0] PLEN_LO_POS     = 16'd19;
   localparam logic [15:0] NXT_POS         = 16'd20;
   localparam logic [15:0] SRC_START_POS   = 16'd22;
   localparam logic [15:0] DST_START_POS   = 16'd38;

   localparam logic [15:0] IPV6_FRAME_TYPE = 16'h86DD;
   localparam logic [7:0]  MULTICAST_BYTE  = 8'hFF;
   localparam logic [7:0]  PROTO_ICMPV6    = 8'd58;
   localparam logic [7:0]  PROTO_TCP       = 8'd6;
   localparam logic [7:0]  PROTO_UDP       = 8'd17;
   localparam logic [15:0] CKS_ZERO        = 16'h0000;
   localparam logic [15:0] CKS_ONES        = 16'hFFFF;

   localparam logic [1:0] VERDICT_FORWARD     = 2'd0;
   localparam logic [1:0] VERDICT_NOT_HANDLED = 2'd1;
   localparam logic [1:0] VERDICT_BAD_CKS     = 2'd2;
   localparam logic [1:0] VERDICT_TOO_SHORT   = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  verdict;
      logic [15:0] checksum_value;
      logic [7:0]  upper_protocol;
   } rsp_type;

   // Per-frame parse state; also used as the snapshot taken at the last byte.
   typedef struct packed {
      logic [15:0] byte_position;
      logic [15:0] frame_type;
      logic [7:0]  dest_first_byte;
      logic [7:0]  next_header;
      logic [15:0] payload_length;
      logic [15:0] running_sum;
      logic [7:0]  held_high_byte;
      logic [15:0] payload_count;
   } frame_state_type;

   // Partial checksum and early verdict passed between the two finish stages.
   typedef struct packed {
      logic        need_sum;
      logic [1:0]  verdict;
      logic [15:0] partial_sum;
      logic [7:0]  next_header;
   } sum_stage_type;

   // 16-bit ones-complement add with end-around carry.
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage

@@ design/ifcf_parse.sv @@
module ifcf_parse
   import ifcf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            take,
   input  req_type         req_byte,
   output frame_state_type updated
);

   frame_state_type state_ff, state_in;
   logic [15:0] p;
   logic [7:0]  b;
   logic        summed;

   always_comb begin
      p       = state_ff.byte_position;
      b       = req_byte.data_byte;
      updated = state_ff;
      summed  = 1'b0;
      if (p < MAX_FRAME_BYTES) begin
         if (p == TYPE_HI_POS) updated.frame_type[15:8] = b;
         if (p == TYPE_LO_POS) updated.frame_type[7:0] = b;
         if (p == PLEN_HI_POS) updated.payload_length[15:8] = b;
         if (p == PLEN_LO_POS) updated.payload_length[7:0] = b;
         if (p == NXT_POS) updated.next_header = b;
         if (p == DST_START_POS) updated.dest_first_byte = b;
         if (p >= SRC_START_POS && p < IP6_END_BYTES) summed = 1'b1;
         if (p >= IP6_END_BYTES && state_ff.payload_count < state_ff.payload_length) begin
            summed = 1'b1;
            updated.payload_count = state_ff.payload_count + 16'd1;
         end
         if (summed) begin
            if (!p[0]) begin
               updated.held_high_byte = b;
            end else begin
               updated.running_sum = oc_add(state_ff.running_sum,
                                            {state_ff.held_high_byte, b});
            end
         end
         updated.byte_position = p + 16'd1;
      end
   end

   // The whole frame state starts over after each final byte.
   always_comb begin
      state_in = state_ff;
      if (take) begin
         state_in = req_byte.last_byte ? '0 : updated;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/ifcf_verdict.sv @@
module ifcf_verdict
   import ifcf_pkg::*;
(
   input  logic            clock,
   input  logic            load_snap,
   input  logic            load_sum,
   input  frame_state_type snap_in,
   output rsp_type         result
);

   frame_state_type snap_ff;
   sum_stage_type   sum_ff, sum_in;
   logic            proto_ok;
   logic [15:0]     sum1;
   logic [15:0]     sum3;
   logic [15:0]     cks;

   always_ff @(posedge clock) begin
      if (load_snap) begin
         snap_ff <= snap_in;
      end
      if (load_sum) begin
         sum_ff <= sum_in;
      end
   end

   // First finish stage: ordered checks plus the odd-byte pad and length terms.
   always_comb begin
      proto_ok = snap_ff.next_header == PROTO_ICMPV6 || snap_ff.next_header == PROTO_TCP ||
                 snap_ff.next_header == PROTO_UDP;
      sum1 = snap_ff.payload_count[0] ?
             oc_add(snap_ff.running_sum, {snap_ff.held_high_byte, 8'h00}) :
             snap_ff.running_sum;
      sum_in.partial_sum = oc_add(sum1, snap_ff.payload_length);
      sum_in.next_header = snap_ff.next_header;
      sum_in.need_sum    = 1'b0;
      if (snap_ff.byte_position < ETH_HDR_BYTES) begin
         sum_in.verdict = VERDICT_TOO_SHORT;
      end else if (snap_ff.frame_type != IPV6_FRAME_TYPE) begin
         sum_in.verdict = VERDICT_NOT_HANDLED;
      end else if (snap_ff.byte_position < IP6_END_BYTES) begin
         sum_in.verdict = VERDICT_TOO_SHORT;
      end else if (snap_ff.dest_first_byte == MULTICAST_BYTE) begin
         sum_in.verdict = VERDICT_NOT_HANDLED;
      end else if (!proto_ok) begin
         sum_in.verdict = VERDICT_NOT_HANDLED;
      end else if (snap_ff.payload_count < snap_ff.payload_length) begin
         sum_in.verdict = VERDICT_TOO_SHORT;
      end else begin
         sum_in.verdict  = VERDICT_FORWARD;
         sum_in.need_sum = 1'b1;
      end
   end

   // Second finish stage: next header term, complement and final verdict.
   always_comb begin
      sum3                  = oc_add(sum_ff.partial_sum, {8'h00, sum_ff.next_header});
      cks                   = ~sum3;
      result.upper_protocol = sum_ff.next_header;
      if (sum_ff.need_sum) begin
         result.checksum_value = cks;
         result.verdict = (cks == CKS_ZERO || cks == CKS_ONES) ? VERDICT_FORWARD :
                                                                 VERDICT_BAD_CKS;
      end else begin
         result.checksum_value = CKS_ZERO;
         result.verdict        = sum_ff.verdict;
      end
   end

endmodule

@@ design/ipv6_frame_checksum_filter.sv @@
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid, req_ready | req_data  (req_type: data_byte, last_byte)
// rsp     | out       | rsp_valid, rsp_ready | rsp_data  (rsp_type: verdict,
//         |           |                      |            checksum_value, upper_protocol)
//
// One frame byte is taken every cycle unless a stalled final byte holds the input
// register; only final bytes produce a response, via the snapshot, sum and response registers.
// The rate is set by the running ones-complement adder in the byte parser.
// Reset is synchronous and active high and clears the parser's frame state and all valid flags.
// When rsp_ready is low the pipeline keeps filling its empty stages, and a
// request holding a non-final byte is always taken once the input register moves.
module ipv6_frame_checksum_filter
   import ifcf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // Pipeline: input register, frame parser feeding a snapshot register at the
   // final byte, a partial-sum register, and the response register.
   req_type         in_ff;
   logic            in_valid_ff, in_valid_in;
   logic            snap_valid_ff, snap_valid_in;
   logic            sum_valid_ff, sum_valid_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff;
   frame_state_type updated;
   rsp_type         result;

   logic out_free, sum_adv, sum_free, snap_adv, snap_free, in_adv;

   // Each stage moves when the one after it is empty or moving too.
   // Non-final bytes never need the finish stages, so they only wait on nothing.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign sum_adv   = sum_valid_ff && out_free;
   assign sum_free  = !sum_valid_ff || out_free;
   assign snap_adv  = snap_valid_ff && sum_free;
   assign snap_free = !snap_valid_ff || sum_free;
   assign in_adv    = in_valid_ff && (!in_ff.last_byte || snap_free);
   assign req_ready = !in_valid_ff || in_adv;

   assign in_valid_in   = (req_valid && req_ready) || (in_valid_ff && !in_adv);
   assign snap_valid_in = (in_adv && in_ff.last_byte) || (snap_valid_ff && !snap_adv);
   assign sum_valid_in  = snap_adv || (sum_valid_ff && !sum_adv);
   assign rsp_valid_in  = sum_adv || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         snap_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         snap_valid_ff <= snap_valid_in;
         sum_valid_ff  <= sum_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (sum_adv) begin
         rsp_ff <= result;
      end
   end

   // The parser commits a byte exactly once, when it leaves the input register.
   ifcf_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .take     (in_adv),
      .req_byte (in_ff),
      .updated  (updated)
   );

   ifcf_verdict u_verdict (
      .clock     (clock),
      .load_snap (in_adv && in_ff.last_byte),
      .load_sum  (snap_adv),
      .snap_in   (updated),
      .result    (result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A fresh response must have come out of the partial-sum stage.
   a_rsp_from_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(sum_valid_ff))
      else $error("response appeared without a finished checksum stage");

   // Forwarded frames always carry a good checksum.
   a_forward_good: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.verdict == VERDICT_FORWARD) |->
      (rsp_ff.checksum_value == CKS_ZERO || rsp_ff.checksum_value == CKS_ONES))
      else $error("forward verdict with a bad checksum");

   // Frames that never reach the checksum report a zero checksum field.
   a_unused_cks_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.verdict == VERDICT_NOT_HANDLED ||
                        rsp_ff.verdict == VERDICT_TOO_SHORT)) |->
      (rsp_ff.checksum_value == CKS_ZERO))
      else $error("checksum field not zero for an unchecked frame");

   // A blocked snapshot stays valid and the partial-sum stage holds while it waits.
   a_no_snapshot_overrun: assert property (@(posedge clock) disable iff (reset)
      (snap_valid_ff && !sum_free) |=> (snap_valid_ff && $stable(sum_valid_ff)))
      else $error("snapshot stage lost or overwritten while stalled");

endmodule

@@ tb/ipv6_frame_verdict_checker.sv @@
`timescale 1ns / 100ps

module ipv6_frame_verdict_checker
   import ifcf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      verdicts_pending
);

   typedef struct packed {
      logic [15:0] position;
      logic [15:0] frame_type;
      logic [7:0]  dest_first;
      logic [7:0]  next_header;
      logic [15:0] payload_length;
      logic [15:0] running_sum;
      logic [7:0]  held_high;
      logic [15:0] payload_count;
   } parse_state_type;

   parse_state_type parse;
   rsp_type         expected_verdicts[$];

   function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Advances the parse state by one frame byte; the final byte yields a verdict.
   task automatic predict_frame_byte(input logic [7:0] b, input logic last);
      logic [15:0] pos;
      logic        summed;
      logic        proto_ok;
      logic [15:0] sum;
      rsp_type     want;
      pos = parse.position;
      if (pos != MAX_FRAME_BYTES) begin
         summed = 1'b0;
         if (pos == TYPE_HI_POS) parse.frame_type[15:8] = b;
         if (pos == TYPE_LO_POS) parse.frame_type[7:0] = b;
         if (pos == PLEN_HI_POS) parse.payload_length[15:8] = b;
         if (pos == PLEN_LO_POS) parse.payload_length[7:0] = b;
         if (pos == NXT_POS) parse.next_header = b;
         if (pos == DST_START_POS) parse.dest_first = b;
         if (pos >= SRC_START_POS && pos < IP6_END_BYTES) summed = 1'b1;
         if (pos >= IP6_END_BYTES && parse.payload_count < parse.payload_length) begin
            summed = 1'b1;
            parse.payload_count = parse.payload_count + 16'd1;
         end
         if (summed) begin
            if (!pos[0]) begin
               parse.held_high = b;
            end else begin
               parse.running_sum = fold_add(parse.running_sum, {parse.held_high, b});
            end
         end
         parse.position = pos + 16'd1;
      end
      if (last) begin
         proto_ok = parse.next_header == PROTO_ICMPV6 || parse.next_header == PROTO_TCP ||
                    parse.next_header == PROTO_UDP;
         want.checksum_value = CKS_ZERO;
         want.upper_protocol = parse.next_header;
         if (parse.position < ETH_HDR_BYTES) begin
            want.verdict = VERDICT_TOO_SHORT;
         end else if (parse.frame_type != IPV6_FRAME_TYPE) begin
            want.verdict = VERDICT_NOT_HANDLED;
         end else if (parse.position < IP6_END_BYTES) begin
            want.verdict = VERDICT_TOO_SHORT;
         end else if (parse.dest_first == MULTICAST_BYTE || !proto_ok) begin
            want.verdict = VERDICT_NOT_HANDLED;
         end else if (parse.payload_count < parse.payload_length) begin
            want.verdict = VERDICT_TOO_SHORT;
         end else begin
            sum = parse.running_sum;
            if (parse.payload_count[0]) sum = fold_add(sum, {parse.held_high, 8'h00});
            sum = fold_add(sum, parse.payload_length);
            sum = fold_add(sum, {8'h00, parse.next_header});
            want.checksum_value = ~sum;
            want.verdict = (want.checksum_value == CKS_ZERO || want.checksum_value == CKS_ONES) ?
                           VERDICT_FORWARD : VERDICT_BAD_CKS;
         end
         expected_verdicts.push_back(want);
         parse = '0;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         parse = '0;
         expected_verdicts.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch("unexpected verdict", {14'd0, rsp_data.verdict}, 16'd0);
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_data.verdict != want.verdict)
                  report_mismatch("verdict", {14'd0, rsp_data.verdict}, {14'd0, want.verdict});
               if (rsp_data.checksum_value != want.checksum_value)
                  report_mismatch("checksum_value", rsp_data.checksum_value,
                                  want.checksum_value);
               if (rsp_data.upper_protocol != want.upper_protocol)
                  report_mismatch("upper_protocol", {8'd0, rsp_data.upper_protocol},
                                  {8'd0, want.upper_protocol});
            end
         end
         if (req_valid && req_ready) predict_frame_byte(req_data.data_byte, req_data.last_byte);
      end
      verdicts_pending <= expected_verdicts.size();
   end

endmodule

@@ tb/ipv6_frame_checksum_filter_test.sv @@
`timescale 1ns / 100ps

// Stimulus and verdict for the IPv6 checksum filter. Frames are built byte by
// byte in a queue and sent one request per byte; the checker beside the block
// predicts each verdict and counts mismatches.
module ipv6_frame_checksum_filter_test;
   import ifcf_pkg::*;

   // Cycles with no accepted request or response before the run is declared hung.
   // The longest legal quiet stretch is the deliberate response hold-off.
   localparam int STALL_LIMIT     = 4000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_BYTES    = 300;
   localparam int MIN_FRAMES      = 4;
   localparam int DRAIN_CYCLES    = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int mismatch_count;
   int verdicts_pending;
   int idle_cycles = 0;
   int bytes_sent = 0;
   int frames_sent = 0;

   // The frame being sent, byte 0 first.
   logic [7:0] frame[$];
   // When set, the current frame goes out back to back with no gaps.
   logic       steady = 1'b0;
   // Raised by the sender to ask the response side for its long hold-off.
   logic       hold_off_go = 1'b0;
   logic       hold_off_busy = 1'b0;
   logic       hold_off_done = 1'b0;

   ipv6_frame_checksum_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   ipv6_frame_verdict_checker verdict_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .mismatch_count   (mismatch_count),
      .verdicts_pending (verdicts_pending)
   );

   always #5 clock = ~clock;

   // Mostly back to back or short gaps, with an occasional long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   // Folded sum over the pseudo-header and the first plen payload bytes of the
   // frame in the queue. The caller makes sure all plen payload bytes are there.
   function automatic logic [15:0] pseudo_sum(input int plen);
      logic [15:0] s;
      logic [7:0]  lo;
      int          p;
      int          k;
      s = 16'd0;
      for (p = 22; p < 54; p += 2) s = ones_add(s, {frame[p], frame[p + 1]});
      for (k = 0; k < plen; k += 2) begin
         lo = (k + 1 < plen) ? frame[55 + k] : 8'h00;
         s = ones_add(s, {frame[54 + k], lo});
      end
      s = ones_add(s, plen[15:0]);
      s = ones_add(s, {8'h00, frame[20]});
      return s;
   endfunction

   task automatic fill_random(input int n);
      frame.delete();
      repeat (n) frame.push_back(8'($urandom));
   endtask

   task automatic truncate_frame(input int n);
      while (frame.size() > n) void'(frame.pop_back());
   endtask

   // Builds an Ethernet + IPv6 frame with plen in the header, 'supplied' payload
   // bytes and 'pad' trailing bytes. With fix set, plen of at least 2 and the whole
   // payload present, the first payload word is chosen so that the checksum comes out good.
   task automatic build_ipv6(input logic [7:0] proto, input int plen, input int supplied,
                             input int pad, input logic multicast, input logic fix);
      logic [15:0] s;
      logic [15:0] len16;
      len16 = plen[15:0];
      fill_random(54 + supplied + pad);
      frame[12] = IPV6_FRAME_TYPE[15:8];
      frame[13] = IPV6_FRAME_TYPE[7:0];
      frame[18] = len16[15:8];
      frame[19] = len16[7:0];
      frame[20] = proto;
      frame[38] = multicast ? MULTICAST_BYTE : 8'($urandom_range(0, 254));
      if (fix && plen >= 2 && supplied >= plen) begin
         frame[54] = 8'h00;
         frame[55] = 8'h00;
         s = ~pseudo_sum(plen);
         frame[54] = s[15:8];
         frame[55] = s[7:0];
      end
   endtask

   function automatic logic [7:0] pick_proto();
      case ($urandom_range(0, 2))
         0: return PROTO_ICMPV6;
         1: return PROTO_TCP;
         default: return PROTO_UDP;
      endcase
   endfunction

   // Offers one byte and holds it until accepted. Ready is sampled at the falling
   // edge, where it already has the value the next rising edge will see.
   task automatic send_byte(input logic [7:0] b, input logic last);
      logic accepted;
      int   gap;
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, last_byte: last};
      do begin
         @(negedge clock);
         accepted = req_ready;
         @(posedge clock);
      end while (!accepted);
      bytes_sent++;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_frame();
      int i;
      for (i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
      frames_sent++;
   endtask

   // One random frame: mostly well-formed IPv6 with good checksums, the rest
   // damaged in one way or another.
   task automatic send_random_frame();
      int          r;
      int          plen;
      logic [7:0]  proto;
      r = $urandom_range(0, 99);
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 300) : $urandom_range(0, 48);
      steady = ($urandom_range(0, 3) == 0);
      if (r < 65) begin
         build_ipv6(pick_proto(), plen, plen, ($urandom_range(0, 2) == 0) ?
                    $urandom_range(1, 8) : 0, 1'b0, $urandom_range(0, 4) != 0);
      end else if (r < 72) begin
         build_ipv6(pick_proto(), plen, plen, 0, 1'b0, 1'b1);
         truncate_frame($urandom_range(1, frame.size() - 1));
      end else if (r < 78) begin
         plen = plen + 1;
         build_ipv6(pick_proto(), plen, $urandom_range(0, plen - 1), 0, 1'b0, 1'b0);
      end else if (r < 84) begin
         build_ipv6(pick_proto(), plen, plen, 0, 1'b1, 1'b1);
      end else if (r < 90) begin
         proto = 8'($urandom);
         build_ipv6(proto, plen, plen, 0, 1'b0, 1'b1);
      end else if (r < 95) begin
         build_ipv6(pick_proto(), plen, plen, 0, 1'b0, 1'b1);
         frame[12] = 8'($urandom);
         frame[13] = 8'($urandom);
      end else begin
         fill_random($urandom_range(1, 80));
      end
      send_frame();
   endtask

   // Response side: random runs of ready and stalls, plus one long hold-off
   // while the sender keeps pushing requests at the block.
   initial begin
      int run;
      int gap;
      rsp_ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_go && !hold_off_done) begin
            hold_off_busy = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_busy = 1'b0;
            hold_off_done = 1'b1;
         end else begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) :
                                                 $urandom_range(1, 30);
            rsp_ready <= 1'b1;
            repeat (run) @(posedge clock);
            gap = pick_gap();
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   // Watchdog: any accepted request or response restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int i;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // A frame that is nothing but its final byte.
      fill_random(1);
      send_frame();
      // Ends inside the Ethernet header.
      fill_random(13);
      send_frame();
      // A bare Ethernet header claiming IPv6, and one carrying another ethertype.
      fill_random(14);
      frame[12] = IPV6_FRAME_TYPE[15:8];
      frame[13] = IPV6_FRAME_TYPE[7:0];
      send_frame();
      fill_random(14);
      frame[12] = 8'h08;
      frame[13] = 8'h00;
      send_frame();
      // IPv6 header one byte short, then exactly complete with no payload.
      build_ipv6(PROTO_UDP, 0, 0, 0, 1'b0, 1'b0);
      truncate_frame(53);
      send_frame();
      build_ipv6(PROTO_UDP, 0, 0, 0, 1'b0, 1'b0);
      send_frame();
      // Multicast destination and an unhandled next header.
      build_ipv6(PROTO_ICMPV6, 8, 8, 0, 1'b1, 1'b1);
      send_frame();
      build_ipv6(8'h00, 8, 8, 0, 1'b0, 1'b1);
      send_frame();
      // Payload shorter than the header says, including the largest length.
      build_ipv6(PROTO_TCP, 10, 5, 0, 1'b0, 1'b0);
      send_frame();
      build_ipv6(PROTO_UDP, 16'hFFFF, 10, 0, 1'b0, 1'b0);
      send_frame();
      // Good checksums: odd length padded with zero, and trailing Ethernet padding.
      build_ipv6(PROTO_ICMPV6, 9, 9, 0, 1'b0, 1'b1);
      send_frame();
      build_ipv6(PROTO_TCP, 20, 20, 6, 1'b0, 1'b1);
      send_frame();
      // Random payload, most likely a bad checksum.
      build_ipv6(PROTO_UDP, 12, 12, 0, 1'b0, 1'b0);
      send_frame();
      // All-zero and all-ones frames.
      frame.delete();
      repeat (60) frame.push_back(8'h00);
      send_frame();
      frame.delete();
      repeat (60) frame.push_back(8'hFF);
      send_frame();

      // Hold the response side off and keep pushing thirty one-byte frames, each of
      // which produces a verdict, so that the block stalls its requests.
      steady = 1'b1;
      hold_off_go = 1'b1;
      wait (hold_off_busy);
      for (i = 0; i < 30; i++) begin
         fill_random(1);
         send_frame();
      end
      steady = 1'b0;

      bytes_sent = 0;
      frames_sent = 0;
      while (bytes_sent < RANDOM_BYTES || frames_sent < MIN_FRAMES) send_random_frame();

      req_valid <= 1'b0;
      do @(posedge clock); while (verdicts_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
